[hw/rtl/framebuffer_shape_fill_assert.svh]
// Assertion macros shared by the framebuffer shape fill checker.
`ifndef FRAMEBUFFER_SHAPE_FILL_ASSERT_SVH
`define FRAMEBUFFER_SHAPE_FILL_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define FSF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("framebuffer_shape_fill assertion failed");

// Consequent checked in the cycle after the antecedent.
`define FSF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("framebuffer_shape_fill assertion failed");

`endif

[hw/rtl/fsf_pkg.sv]
// Types, constants and codes shared by the framebuffer shape fill modules.
package fsf_pkg;

    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 128;

    localparam int FW  = 8;        // frame size register width
    localparam int CW  = 12;       // command coordinate width
    localparam int BW  = 14;       // width of clipped bounds and distances
    localparam int SQW = 2 * BW;   // width of squared distances
    localparam int PXW = 32;       // pixel width
    localparam int IXW = 2;        // register index width

    localparam logic [FW-1:0] FRAME_RESET = FW'(128);

    localparam logic [1:0] OP_FILL   = 2'd0;
    localparam logic [1:0] OP_RECT   = 2'd1;
    localparam logic [1:0] OP_CIRCLE = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    localparam logic [IXW-1:0] REG_FRAME_WIDTH  = IXW'(0);
    localparam logic [IXW-1:0] REG_FRAME_HEIGHT = IXW'(1);

    typedef struct packed {
        logic [1:0]           operation;
        logic signed [CW-1:0] pos_x;
        logic signed [CW-1:0] pos_y;
        logic [CW-1:0]        box_width;
        logic [CW-1:0]        box_height;
        logic signed [CW-1:0] radius;
        logic [PXW-1:0]       color;
    } cmd_t;

    typedef struct packed {
        logic [PXW-1:0] pixel;
        logic           in_range;
    } rsp_t;

    typedef struct packed {
        logic capture;
        logic clip;
        logic prep;
        logic step;
        logic mem_read;
        logic rsp_load;
    } dp_cmd_t;

    typedef struct packed {
        logic is_read;
        logic empty;
        logic last;
    } dp_status_t;

endpackage

[hw/rtl/fsf_ctrl.sv]
// Sequencer for the framebuffer shape fill: handshakes and datapath commands.
module fsf_ctrl
    import fsf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    input  dp_status_t status,
    output dp_cmd_t    ctl
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CLIP = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_RUN  = 3'd3;
    localparam logic [2:0] S_READ = 3'd4;
    localparam logic [2:0] S_RESP = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic       rsp_free;

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = S_CLIP;
                end
            end
            S_CLIP:
            begin
                ctl.clip   = 1'b1;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                ctl.prep = 1'b1;
                priority if (status.is_read)
                    state_next = S_READ;
                else if (status.empty)
                    state_next = S_IDLE;
                else
                    state_next = S_RUN;
            end
            S_RUN:
            begin
                ctl.step = 1'b1;
                if (status.last)
                    state_next = S_IDLE;
            end
            S_READ:
            begin
                ctl.mem_read = 1'b1;
                state_next   = S_RESP;
            end
            S_RESP:
            begin
                // The result waits here until the output register has room.
                if (rsp_free)
                begin
                    ctl.rsp_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (ctl.rsp_load)
            rsp_valid_next = 1'b1;
        else if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

[hw/rtl/fsf_datapath.sv]
// Datapath of the framebuffer shape fill: clipping, scan counters, distance test, pixel store.
module fsf_datapath
    import fsf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  cmd_t           cmd_data,
    input  logic           cfg_we,
    input  logic [IXW-1:0] cfg_index,
    input  logic [FW-1:0]  cfg_data,
    input  dp_cmd_t        ctl,
    output dp_status_t     status,
    output rsp_t           rsp_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [PXW-1:0] frame_store [DEPTH];

    logic [FW-1:0] width_reg;
    logic [FW-1:0] height_reg;
    logic [FW-1:0] eff_w;
    logic [FW-1:0] eff_h;

    cmd_t cmd_reg;

    logic signed [BW-1:0] px;
    logic signed [BW-1:0] py;
    logic signed [BW-1:0] wv;
    logic signed [BW-1:0] hv;
    logic signed [BW-1:0] bwv;
    logic signed [BW-1:0] bhv;
    logic signed [BW-1:0] rv;
    logic signed [BW-1:0] lo_x;
    logic signed [BW-1:0] hi_x;
    logic signed [BW-1:0] lo_y;
    logic signed [BW-1:0] hi_y;
    logic signed [BW-1:0] x0;
    logic signed [BW-1:0] x1;
    logic signed [BW-1:0] y0;
    logic signed [BW-1:0] y1;
    logic                 empty;
    logic                 in_frame;

    logic [FW-1:0]        x0_reg;
    logic [FW-1:0]        x1_reg;
    logic [FW-1:0]        y0_reg;
    logic [FW-1:0]        y1_reg;
    logic signed [BW-1:0] dx0_reg;
    logic signed [BW-1:0] dy0_reg;
    logic                 empty_reg;
    logic                 in_range_reg;

    logic signed [SQW-1:0]  dx0_sq;
    logic signed [SQW-1:0]  dy0_sq;
    logic signed [2*CW-1:0] r_sq;
    logic [FW-1:0]          x_sel;
    logic [FW-1:0]          y_sel;
    logic [2*FW-1:0]        row_prod;

    logic signed [SQW-1:0] dx0sq_reg;
    logic signed [SQW-1:0] rr_reg;
    logic signed [SQW-1:0] dx2_reg;
    logic signed [SQW-1:0] dy2_reg;
    logic signed [BW-1:0]  dx_reg;
    logic signed [BW-1:0]  dy_reg;
    logic [FW-1:0]         x_reg;
    logic [FW-1:0]         y_reg;
    logic [AW-1:0]         row_reg;
    logic [AW-1:0]         addr_reg;

    logic signed [SQW-1:0] dx_inc;
    logic signed [SQW-1:0] dy_inc;
    logic signed [SQW-1:0] dist_sq;
    logic [AW-1:0]         row_next;
    logic                  last_x;
    logic                  covered;

    logic [PXW-1:0] rd_reg;
    rsp_t           rsp_reg;

    // The frame size in use saturates to the store dimensions.
    assign eff_w = (32'(width_reg) > MAX_WIDTH) ? FW'(MAX_WIDTH) : width_reg;
    assign eff_h = (32'(height_reg) > MAX_HEIGHT) ? FW'(MAX_HEIGHT) : height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= FRAME_RESET;
            height_reg <= FRAME_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_FRAME_WIDTH)
                width_reg <= cfg_data;
            if (cfg_index == REG_FRAME_HEIGHT)
                height_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
            cmd_reg <= cmd_data;
    end

    // Clip stage: bounds of the region to scan, clipped to the frame.
    assign px  = BW'(cmd_reg.pos_x);
    assign py  = BW'(cmd_reg.pos_y);
    assign rv  = BW'(cmd_reg.radius);
    assign wv  = $signed(BW'(eff_w));
    assign hv  = $signed(BW'(eff_h));
    assign bwv = $signed(BW'(cmd_reg.box_width));
    assign bhv = $signed(BW'(cmd_reg.box_height));

    always_comb
    begin
        unique case (cmd_reg.operation)
            OP_RECT:
            begin
                lo_x = px;
                hi_x = px + bwv - BW'(1);
                lo_y = py;
                hi_y = py + bhv - BW'(1);
            end
            OP_CIRCLE:
            begin
                lo_x = px - rv;
                hi_x = px + rv;
                lo_y = py - rv;
                hi_y = py + rv;
            end
            default:
            begin
                lo_x = '0;
                hi_x = wv - BW'(1);
                lo_y = '0;
                hi_y = hv - BW'(1);
            end
        endcase
    end

    assign x0 = (lo_x < 0) ? '0 : lo_x;
    assign y0 = (lo_y < 0) ? '0 : lo_y;
    assign x1 = (hi_x > wv - BW'(1)) ? wv - BW'(1) : hi_x;
    assign y1 = (hi_y > hv - BW'(1)) ? hv - BW'(1) : hi_y;

    assign empty    = (x0 > x1) || (y0 > y1)
                   || ((cmd_reg.operation == OP_CIRCLE) && cmd_reg.radius[CW-1]);
    assign in_frame = (px >= 0) && (px < wv) && (py >= 0) && (py < hv);

    always_ff @(posedge clk)
    begin
        if (ctl.clip)
        begin
            x0_reg       <= FW'(x0);
            x1_reg       <= FW'(x1);
            y0_reg       <= FW'(y0);
            y1_reg       <= FW'(y1);
            dx0_reg      <= x0 - px;
            dy0_reg      <= y0 - py;
            empty_reg    <= empty;
            in_range_reg <= in_frame;
        end
    end

    // Prep stage: squares and the start address, one multiply per path.
    assign dx0_sq   = SQW'(dx0_reg) * SQW'(dx0_reg);
    assign dy0_sq   = SQW'(dy0_reg) * SQW'(dy0_reg);
    assign r_sq     = (2*CW)'(cmd_reg.radius) * (2*CW)'(cmd_reg.radius);
    assign x_sel    = (cmd_reg.operation == OP_READ) ? FW'(cmd_reg.pos_x) : x0_reg;
    assign y_sel    = (cmd_reg.operation == OP_READ) ? FW'(cmd_reg.pos_y) : y0_reg;
    assign row_prod = (2*FW)'(y_sel) * (2*FW)'(eff_w);

    // Scan step: squared distances advance by 2d+1 per unit move.
    assign dx_inc   = (SQW'(dx_reg) <<< 1) + SQW'(1);
    assign dy_inc   = (SQW'(dy_reg) <<< 1) + SQW'(1);
    assign dist_sq  = dx2_reg + dy2_reg;
    assign row_next = row_reg + AW'(eff_w);
    assign last_x   = (x_reg == x1_reg);
    assign covered  = (cmd_reg.operation != OP_CIRCLE) || (dist_sq <= rr_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.prep)
        begin
            dx0sq_reg <= dx0_sq;
            dx2_reg   <= dx0_sq;
            dy2_reg   <= dy0_sq;
            rr_reg    <= SQW'($unsigned(r_sq));
            dx_reg    <= dx0_reg;
            dy_reg    <= dy0_reg;
            x_reg     <= x0_reg;
            y_reg     <= y0_reg;
            row_reg   <= AW'(row_prod);
            addr_reg  <= AW'(row_prod + (2*FW)'(x_sel));
        end
        else if (ctl.step)
        begin
            if (last_x)
            begin
                x_reg    <= x0_reg;
                y_reg    <= y_reg + FW'(1);
                row_reg  <= row_next;
                addr_reg <= row_next + AW'(x0_reg);
                dx_reg   <= dx0_reg;
                dx2_reg  <= dx0sq_reg;
                dy_reg   <= dy_reg + BW'(1);
                dy2_reg  <= dy2_reg + dy_inc;
            end
            else
            begin
                x_reg    <= x_reg + FW'(1);
                addr_reg <= addr_reg + AW'(1);
                dx_reg   <= dx_reg + BW'(1);
                dx2_reg  <= dx2_reg + dx_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.step && covered)
            frame_store[addr_reg] <= cmd_reg.color;
        if (ctl.mem_read)
            rd_reg <= frame_store[addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rsp_load)
        begin
            rsp_reg.pixel    <= in_range_reg ? rd_reg : '0;
            rsp_reg.in_range <= in_range_reg;
        end
    end

    assign rsp_data       = rsp_reg;
    assign status.is_read = (cmd_reg.operation == OP_READ);
    assign status.empty   = empty_reg;
    assign status.last    = last_x && (y_reg == y1_reg);

endmodule

[hw/rtl/framebuffer_shape_fill.sv]
// Top level of the framebuffer shape fill: sequencer, datapath and ports.
//
//  channel   direction  handshake           payload
//  cmd       in         cmd_valid/stall     cmd_t: operation, position, box, radius, color
//  rsp       out        rsp_valid/stall     rsp_t: pixel, in_range (reads only)
//  cfg       in         cfg_valid/ready     cfg_index, cfg_data (frame width, height)
//
// A draw request passes the clip and prep setup states, then writes one pixel per
// cycle over the clipped bounding box; the single write port of the pixel store
// sets that pace. A read passes clip, prep and a store read, then loads its result
// into the output register. The pixel store is not cleared at reset; a held response
// does not block the next request, only a later read waits for the output register.
module framebuffer_shape_fill
    import fsf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  cmd_t           cmd_data,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output rsp_t           rsp_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [IXW-1:0] cfg_index,
    input  logic [FW-1:0]  cfg_data
);

    dp_cmd_t    ctl;
    dp_status_t status;

    // The user must change the frame size only while idle; the block does not enforce it, and writes are always taken.
    assign cfg_ready = 1'b1;

    fsf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .ctl       (ctl)
    );

    fsf_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_data  (cmd_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctl       (ctl),
        .status    (status),
        .rsp_data  (rsp_data)
    );

endmodule

[hw/rtl/fsf_checker.sv]
// Port-level checker for the framebuffer shape fill, bound to the top level.
`include "framebuffer_shape_fill_assert.svh"

module fsf_checker
    import fsf_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic cmd_valid,
    input logic cmd_stall,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp_data
);

    `FSF_ASSERT_NEXT(a_rsp_held, rsp_valid && rsp_stall, rsp_valid)
    `FSF_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_data))
    // Only one request is in work at a time.
    `FSF_ASSERT_NEXT(a_busy_after_accept, cmd_valid && !cmd_stall, cmd_stall)
    // A new response appears only as a read request finishes.
    `FSF_ASSERT_SAME(a_rsp_from_read, $rose(rsp_valid), $past(cmd_stall))
    // A coordinate outside the frame reads as zero.
    `FSF_ASSERT_SAME(a_out_of_range_zero, rsp_valid && !rsp_data.in_range,
                     rsp_data.pixel == '0)

endmodule

bind framebuffer_shape_fill fsf_checker u_checker (.*);
